// ----- rtl/crcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfr_pkg
// Types, codes and the CRC16 byte update shared by the framed receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // event codes from front to back
    localparam logic [2:0] EV_LEN    = 3'd0;
    localparam logic [2:0] EV_CMD    = 3'd1;
    localparam logic [2:0] EV_PAY    = 3'd2;
    localparam logic [2:0] EV_CRC_LO = 3'd3;
    localparam logic [2:0] EV_CRC_HI = 3'd4;
    localparam logic [2:0] EV_TAIL   = 3'd5;
    localparam logic [2:0] EV_OVER   = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CRC_ERR  = 3'd1;
    localparam logic [2:0] ST_LEN_ERR  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_BAD_TAIL = 3'd4;
    localparam logic [2:0] ST_OVERLONG = 3'd5;

    localparam logic [7:0] CMD_STORE_FIRST = 8'd1;
    localparam logic [7:0] CMD_STORE_LAST  = 8'd4;
    localparam logic [7:0] CMD_QUERY       = 8'd5;
    localparam logic [7:0] CMD_HEARTBEAT   = 8'd6;
    localparam logic [1:0] ZONE_CMD1       = 2'd3;

    localparam logic [0:0] KIND_PAYLOAD = 1'b0;
    localparam logic [0:0] KIND_VERDICT = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [4:0] idx;
        logic [4:0] plen;
        logic       len_ok;
        logic       tail_ok;
    } t_ev;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/crc16_framed_command_receiver.sv -----
// Takes one received byte per cycle and hunts for frames of the form head,
// length, command, payload, CRC low, CRC high, tail (MODBUS CRC16 over length,
// command and payload). Payload bytes come out one by one as they arrive; the
// tail byte gives one verdict with command, status and zone. A byte passes the
// combinational classifier into a two-entry queue and then the registered
// CRC/verdict stage, so a new byte is taken every cycle unless the queue is
// full under a stalled output. Configuration writes are always ready.
// ----------------------------------------------------------------------------
// crc16_framed_command_receiver
// Framed command receiver: classifier, event queue and CRC/verdict back end.
// ----------------------------------------------------------------------------
module crc16_framed_command_receiver
    import crcfr_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_command,
    output logic [2:0] o_status,
    output logic [1:0] o_zone,
    output logic [4:0] o_payload_length
);

    localparam logic [1:0] CFG_HEAD    = 2'd0;
    localparam logic [1:0] CFG_TAIL    = 2'd1;
    localparam logic [1:0] CFG_REC_LEN = 2'd2;

    logic [7:0] r_head, r_tail;
    logic [4:0] r_rec_len;

    logic w_take, w_push, w_pop, w_full, w_nonempty;
    t_ev  w_ev_in, w_ev_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_take      = i_in_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= 8'hA5;
            r_tail    <= 8'h5A;
            r_rec_len <= 5'd17;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEAD:    r_head    <= i_cfg_data;
                CFG_TAIL:    r_tail    <= i_cfg_data;
                CFG_REC_LEN: r_rec_len <= i_cfg_data[4:0];
                default:     r_head    <= r_head;
            endcase
        end
    end

    crcfr_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_byte         (i_rx_byte),
        .i_head_byte    (r_head),
        .i_tail_byte    (r_tail),
        .i_record_length(r_rec_len),
        .o_push         (w_push),
        .o_ev           (w_ev_in)
    );

    crcfr_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_ev      (w_ev_in),
        .i_pop     (w_pop),
        .o_full    (w_full),
        .o_nonempty(w_nonempty),
        .o_ev      (w_ev_out)
    );

    crcfr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nonempty      (w_nonempty),
        .i_ev            (w_ev_out),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_byte_index    (o_byte_index),
        .o_command       (o_command),
        .o_status        (o_status),
        .o_zone          (o_zone),
        .o_payload_length(o_payload_length)
    );

endmodule

// ----- rtl/crcfr_front.sv -----
// ----------------------------------------------------------------------------
// crcfr_front
// Tracks the frame position of each received byte and classifies it.
// ----------------------------------------------------------------------------
module crcfr_front
    import crcfr_pkg::*;
#(
    parameter int FRAME_BUFFER_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_head_byte,
    input  logic [7:0] i_tail_byte,
    input  logic [4:0] i_record_length,
    output logic       o_push,
    output t_ev        o_ev
);

    localparam int POS_W = $clog2(FRAME_BUFFER_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_plen, n_plen;
    logic             r_over, n_over;

    logic [8:0] w_p9;
    logic [8:0] w_plen9;
    logic [7:0] w_len_m1;

    assign w_p9     = 9'(r_pos);
    assign w_plen9  = {1'b0, r_plen};
    assign w_len_m1 = i_byte - 8'd1;

    always_comb begin
        n_pos         = r_pos;
        n_plen        = r_plen;
        n_over        = r_over;
        o_push        = 1'b0;
        o_ev.op       = EV_PAY;
        o_ev.data     = i_byte;
        o_ev.idx      = 5'(w_p9 - 9'd3);
        o_ev.plen     = r_plen[4:0];
        o_ev.len_ok   = (r_plen == {3'b000, i_record_length});
        o_ev.tail_ok  = (i_byte == i_tail_byte);
        if (i_take) begin
            priority if (w_p9 == 9'd0) begin
                if (i_byte == i_head_byte) begin
                    n_pos = POS_W'(1);
                end
            end else if (w_p9 == 9'd1) begin
                n_plen  = w_len_m1;
                n_over  = ({1'b0, w_len_m1} + 9'd6) > 9'(FRAME_BUFFER_BYTES);
                o_push  = 1'b1;
                o_ev.op = EV_LEN;
                n_pos   = POS_W'(2);
            end else if (w_p9 == 9'd2) begin
                o_push  = 1'b1;
                o_ev.op = EV_CMD;
                n_pos   = POS_W'(3);
            end else if (r_over) begin
                if (w_p9 >= 9'(FRAME_BUFFER_BYTES - 1)) begin
                    o_push  = 1'b1;
                    o_ev.op = EV_OVER;
                    n_pos   = '0;
                end else begin
                    n_pos = r_pos + POS_W'(1);
                end
            end else if (w_p9 < w_plen9 + 9'd3) begin
                o_push  = 1'b1;
                o_ev.op = EV_PAY;
                n_pos   = r_pos + POS_W'(1);
            end else if (w_p9 == w_plen9 + 9'd3) begin
                o_push  = 1'b1;
                o_ev.op = EV_CRC_LO;
                n_pos   = r_pos + POS_W'(1);
            end else if (w_p9 == w_plen9 + 9'd4) begin
                o_push  = 1'b1;
                o_ev.op = EV_CRC_HI;
                n_pos   = r_pos + POS_W'(1);
            end else begin
                o_push  = 1'b1;
                o_ev.op = EV_TAIL;
                n_pos   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_plen <= '0;
            r_over <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_plen <= n_plen;
            r_over <= n_over;
        end
    end

endmodule

// ----- rtl/crcfr_queue.sv -----
// ----------------------------------------------------------------------------
// crcfr_queue
// Short event queue between the classifier and the executing back end.
// ----------------------------------------------------------------------------
module crcfr_queue
    import crcfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_ev  i_ev,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_ev  o_ev
);

    t_ev               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_full     = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_ev       = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ev;
        end
    end

endmodule

// ----- rtl/crcfr_back.sv -----
// ----------------------------------------------------------------------------
// crcfr_back
// Runs the CRC, holds the frame command and builds the registered results.
// ----------------------------------------------------------------------------
module crcfr_back
    import crcfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_nonempty,
    input  t_ev        i_ev,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_command,
    output logic [2:0] o_status,
    output logic [1:0] o_zone,
    output logic [4:0] o_payload_length
);

    logic        r_ov, n_ov;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_cmd, n_cmd;
    logic        r_match, n_match;

    logic       r_kind, n_kind;
    logic [7:0] r_data, n_data;
    logic [4:0] r_idx, n_idx;
    logic [2:0] r_status, n_status;
    logic [1:0] r_zone, n_zone;
    logic [4:0] r_plen, n_plen;
    logic [7:0] r_ocmd, n_ocmd;

    logic [15:0] w_crc_next;
    logic        w_store;

    assign o_pop      = i_nonempty && (!r_ov || !i_out_stall);
    assign w_crc_next = crc_byte((i_ev.op == EV_LEN) ? CRC_INIT : r_crc, i_ev.data);
    assign w_store    = (r_cmd >= CMD_STORE_FIRST) && (r_cmd <= CMD_STORE_LAST);

    always_comb begin
        n_crc    = r_crc;
        n_cmd    = r_cmd;
        n_match  = r_match;
        n_ov     = r_ov && i_out_stall;
        n_kind   = r_kind;
        n_data   = r_data;
        n_idx    = r_idx;
        n_status = r_status;
        n_zone   = r_zone;
        n_plen   = r_plen;
        n_ocmd   = r_ocmd;
        if (o_pop) begin
            unique case (i_ev.op)
                EV_LEN: begin
                    n_crc = w_crc_next;
                end
                EV_CMD: begin
                    n_crc = w_crc_next;
                    n_cmd = i_ev.data;
                end
                EV_PAY: begin
                    n_crc    = w_crc_next;
                    n_ov     = 1'b1;
                    n_kind   = KIND_PAYLOAD;
                    n_data   = i_ev.data;
                    n_idx    = i_ev.idx;
                    n_ocmd   = r_cmd;
                    n_status = ST_OK;
                    n_zone   = '0;
                    n_plen   = i_ev.plen;
                end
                EV_CRC_LO: begin
                    n_match = (i_ev.data == r_crc[7:0]);
                end
                EV_CRC_HI: begin
                    n_match = r_match && (i_ev.data == r_crc[15:8]);
                end
                EV_TAIL: begin
                    n_ov   = 1'b1;
                    n_kind = KIND_VERDICT;
                    n_data = '0;
                    n_idx  = '0;
                    n_ocmd = r_cmd;
                    n_plen = i_ev.plen;
                    n_zone = '0;
                    priority if (!i_ev.tail_ok) begin
                        n_status = ST_BAD_TAIL;
                    end else if (w_store) begin
                        n_zone = (r_cmd == CMD_STORE_FIRST) ? ZONE_CMD1
                                                            : 2'(r_cmd - 8'd2);
                        priority if (!r_match) begin
                            n_status = ST_CRC_ERR;
                        end else if (!i_ev.len_ok) begin
                            n_status = ST_LEN_ERR;
                        end else begin
                            n_status = ST_OK;
                        end
                    end else if (r_cmd == CMD_QUERY || r_cmd == CMD_HEARTBEAT) begin
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_UNKNOWN;
                    end
                end
                EV_OVER: begin
                    n_ov     = 1'b1;
                    n_kind   = KIND_VERDICT;
                    n_data   = '0;
                    n_idx    = '0;
                    n_ocmd   = r_cmd;
                    n_status = ST_OVERLONG;
                    n_zone   = '0;
                    n_plen   = '0;
                end
                default: begin
                    n_crc = r_crc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_crc   <= CRC_INIT;
            r_cmd   <= '0;
            r_match <= 1'b0;
        end else begin
            r_ov    <= n_ov;
            r_crc   <= n_crc;
            r_cmd   <= n_cmd;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_data   <= n_data;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_zone   <= n_zone;
        r_plen   <= n_plen;
        r_ocmd   <= n_ocmd;
    end

    assign o_out_valid      = r_ov;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_byte_index     = r_idx;
    assign o_command        = r_ocmd;
    assign o_status         = r_status;
    assign o_zone           = r_zone;
    assign o_payload_length = r_plen;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb - framed command receiver testbench
// Feeds byte streams of whole, damaged, cut and overlong frames into the
// receiver under random input gaps and output stalls, predicts every payload
// item and frame verdict, and checks each result in order, field by field.
// Header, tail and record length are changed between traffic phases.
// ----------------------------------------------------------------------------
module tb;
    import crcfr_pkg::*;

    localparam int FRAME_BYTES   = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 330;
    localparam int PHASE_ITEMS   = 90;
    localparam int HOLD_CYCLES   = 120;

    localparam logic [1:0] REG_HEAD   = 2'd0;
    localparam logic [1:0] REG_TAIL   = 2'd1;
    localparam logic [1:0] REG_RECLEN = 2'd2;

    typedef enum {CRC_GOOD, CRC_BAD_LO, CRC_BAD_HI, CRC_BAD_BOTH} t_crc_fault;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [4:0] idx;
        logic [7:0] cmd;
        logic [2:0] status;
        logic [1:0] zone;
        logic [4:0] plen;
    } t_frame_event;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_index = REG_HEAD;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_cfg_ready;
    logic       o_out_valid;
    logic       o_kind;
    logic [7:0] o_data_byte;
    logic [4:0] o_byte_index;
    logic [7:0] o_command;
    logic [2:0] o_status;
    logic [1:0] o_zone;
    logic [4:0] o_payload_length;

    // receiver mirror
    logic [7:0]  cfg_head       = 8'hA5;
    logic [7:0]  cfg_tail       = 8'h5A;
    logic [4:0]  cfg_record_len = 5'd17;
    int          fr_pos         = 0;
    logic [7:0]  fr_count       = 8'h00;
    logic [7:0]  fr_cmd         = 8'h00;
    logic [15:0] fr_crc         = CRC_INIT;
    logic        fr_crc_ok      = 1'b0;

    t_frame_event pending_events[$];
    int error_count  = 0;
    int framed_items = 0;
    int cycle_count  = 0;
    int burst_left   = 0;

    bit          hold_request = 1'b0;
    int          hold_left    = 0;
    t_stall_mode stall_mode   = STALL_NONE;
    int          mode_left    = 0;
    int          stall_period = 2;
    int          stall_on     = 1;

    crc16_framed_command_receiver #(
        .FRAME_BUFFER_BYTES(FRAME_BYTES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_byte_index    (o_byte_index),
        .o_command       (o_command),
        .o_status        (o_status),
        .o_zone          (o_zone),
        .o_payload_length(o_payload_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** crc16_framed_command_receiver: FAILED **");
        $finish;
    end

    // bitwise MODBUS CRC, input bit fed in at the LSB
    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0]  d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ d[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void push_event(input logic kind, input logic [7:0] data,
                                       input logic [4:0] idx, input logic [2:0] status,
                                       input logic [1:0] zone, input logic [4:0] plen);
        t_frame_event ev;
        ev.kind   = kind;
        ev.data   = data;
        ev.idx    = idx;
        ev.cmd    = fr_cmd;
        ev.status = status;
        ev.zone   = zone;
        ev.plen   = plen;
        pending_events.push_back(ev);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        logic [2:0] status;
        logic [1:0] zone;
        if (fr_pos == 0) begin
            if (b == cfg_head) begin
                fr_pos    = 1;
                fr_crc    = CRC_INIT;
                fr_crc_ok = 1'b0;
                framed_items++;
            end
            return;
        end
        framed_items++;
        if (fr_pos == 1) begin
            fr_count = b - 8'd1;
            fr_crc   = modbus_crc_step(fr_crc, b);
            fr_pos   = 2;
        end else if (fr_pos == 2) begin
            fr_cmd = b;
            fr_crc = modbus_crc_step(fr_crc, b);
            fr_pos = 3;
        end else if (int'(fr_count) + 6 > FRAME_BYTES) begin
            if (fr_pos >= FRAME_BYTES - 1) begin
                push_event(KIND_VERDICT, 8'h00, 5'd0, ST_OVERLONG, 2'd0, 5'd0);
                fr_pos = 0;
                fr_crc = CRC_INIT;
            end else begin
                fr_pos++;
            end
        end else if (fr_pos < 3 + int'(fr_count)) begin
            push_event(KIND_PAYLOAD, b, 5'(fr_pos - 3), ST_OK, 2'd0, fr_count[4:0]);
            fr_crc = modbus_crc_step(fr_crc, b);
            fr_pos++;
        end else if (fr_pos == 3 + int'(fr_count)) begin
            fr_crc_ok = (b == fr_crc[7:0]);
            fr_pos++;
        end else if (fr_pos == 4 + int'(fr_count)) begin
            fr_crc_ok = fr_crc_ok && (b == fr_crc[15:8]);
            fr_pos++;
        end else begin
            zone = 2'd0;
            if (b != cfg_tail) begin
                status = ST_BAD_TAIL;
            end else if (fr_cmd >= CMD_STORE_FIRST && fr_cmd <= CMD_STORE_LAST) begin
                zone = (fr_cmd == CMD_STORE_FIRST) ? ZONE_CMD1 : 2'(fr_cmd - 8'd2);
                if (!fr_crc_ok) begin
                    status = ST_CRC_ERR;
                end else if (fr_count[4:0] != cfg_record_len) begin
                    status = ST_LEN_ERR;
                end else begin
                    status = ST_OK;
                end
            end else if (fr_cmd == CMD_QUERY || fr_cmd == CMD_HEARTBEAT) begin
                status = ST_OK;
            end else begin
                status = ST_UNKNOWN;
            end
            push_event(KIND_VERDICT, 8'h00, 5'd0, status, zone, fr_count[4:0]);
            fr_pos = 0;
            fr_crc = CRC_INIT;
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_event want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected item, expected none, got kind %0d cmd %0d status %0d",
                         $time, o_kind, o_command, o_status);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("data_byte", want.data, o_data_byte);
                check_field("byte_index", want.idx, o_byte_index);
                check_field("command", want.cmd, o_command);
                check_field("status", want.status, o_status);
                check_field("zone", want.zone, o_zone);
                check_field("payload_length", want.plen, o_payload_length);
            end
        end
    end

    // output stall pattern, with a long hold on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode   = t_stall_mode'($urandom_range(0, 3));
                mode_left    = $urandom_range(32, 200);
                stall_period = $urandom_range(2, 9);
                stall_on     = $urandom_range(1, stall_period - 1);
            end
            mode_left = mode_left - 1;
            case (stall_mode)
                STALL_NONE: begin
                    i_out_stall <= 1'b0;
                end
                STALL_LIGHT: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_HEAVY: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_out_stall <= ((mode_left % stall_period) < stall_on);
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] cmd,
                              input t_crc_fault fault, input bit bad_tail, input int cut);
        logic [7:0]  bytes_out[$];
        logic [7:0]  b;
        logic [7:0]  count;
        logic [15:0] crc;
        bytes_out = {cfg_head, len_byte, cmd};
        crc       = modbus_crc_step(modbus_crc_step(CRC_INIT, len_byte), cmd);
        count     = len_byte - 8'd1;
        if (int'(count) + 6 > FRAME_BYTES) begin
            repeat (FRAME_BYTES - 3) bytes_out.push_back(8'($urandom));
        end else begin
            repeat (int'(count)) begin
                b = 8'($urandom);
                bytes_out.push_back(b);
                crc = modbus_crc_step(crc, b);
            end
            if (fault == CRC_BAD_LO || fault == CRC_BAD_BOTH) begin
                crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
            end
            if (fault == CRC_BAD_HI || fault == CRC_BAD_BOTH) begin
                crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
            end
            bytes_out.push_back(crc[7:0]);
            bytes_out.push_back(crc[15:8]);
            bytes_out.push_back(bad_tail ? cfg_tail ^ 8'($urandom_range(1, 255)) : cfg_tail);
        end
        for (int i = 0; i < bytes_out.size() && (cut < 0 || i < cut); i++) begin
            send_byte(bytes_out[i]);
        end
    endtask

    // sender pauses until every result is out and the pipeline has settled
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_HEAD: begin
                cfg_head = val;
            end
            REG_TAIL: begin
                cfg_tail = val;
            end
            default: begin
                cfg_record_len = val[4:0];
            end
        endcase
    endtask

    task automatic set_config(input logic [7:0] head, input logic [7:0] tail,
                              input logic [4:0] rec_len);
        write_reg(REG_HEAD, head);
        write_reg(REG_TAIL, tail);
        write_reg(REG_RECLEN, {3'b000, rec_len});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_hunting();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'h3C);
        send_frame(8'd1, CMD_HEARTBEAT, CRC_GOOD, 1'b0, -1);
    endtask

    task automatic test_store_commands();
        for (int c = CMD_STORE_FIRST; c <= CMD_STORE_LAST; c++) begin
            send_frame(8'(cfg_record_len) + 8'd1, 8'(c), CRC_GOOD, 1'b0, -1);
        end
    endtask

    task automatic test_crc_and_length();
        send_frame(8'(cfg_record_len) + 8'd1, CMD_STORE_FIRST, CRC_BAD_LO, 1'b0, -1);
        send_frame(8'(cfg_record_len) + 8'd1, 8'd2, CRC_BAD_HI, 1'b0, -1);
        send_frame(8'd5, 8'd3, CRC_GOOD, 1'b0, -1);
        send_frame(8'd5, CMD_STORE_LAST, CRC_BAD_BOTH, 1'b0, -1);
    endtask

    task automatic test_query_heartbeat();
        send_frame(8'd1, CMD_QUERY, CRC_BAD_BOTH, 1'b0, -1);
        send_frame(8'd27, CMD_HEARTBEAT, CRC_GOOD, 1'b0, -1);
        send_frame(8'd3, CMD_QUERY, CRC_GOOD, 1'b0, -1);
    endtask

    task automatic test_unknown_and_tail();
        send_frame(8'd2, 8'd0, CRC_GOOD, 1'b0, -1);
        send_frame(8'd2, 8'd7, CRC_GOOD, 1'b0, -1);
        send_frame(8'd4, 8'd255, CRC_BAD_LO, 1'b0, -1);
        send_frame(8'(cfg_record_len) + 8'd1, 8'd2, CRC_GOOD, 1'b1, -1);
        send_frame(8'd3, 8'd200, CRC_GOOD, 1'b1, -1);
    endtask

    task automatic test_overlong();
        send_frame(8'd28, CMD_STORE_FIRST, CRC_GOOD, 1'b0, -1);
        send_frame(8'd255, CMD_QUERY, CRC_GOOD, 1'b0, -1);
        send_frame(8'd0, 8'd3, CRC_GOOD, 1'b0, -1);
    endtask

    task automatic test_backpressure();
        quiesce();
        hold_request = 1'b1;
        burst_left   = 200;
        send_frame(8'd27, CMD_QUERY, CRC_GOOD, 1'b0, -1);
        send_frame(8'(cfg_record_len) + 8'd1, CMD_STORE_FIRST, CRC_GOOD, 1'b0, -1);
        quiesce();
    endtask

    task automatic random_frame();
        int         r;
        logic [7:0] cmd;
        logic [7:0] len_byte;
        t_crc_fault fault;
        r   = $urandom_range(0, 99);
        cmd = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 6)) : 8'($urandom);
        if ($urandom_range(0, 2) == 0) begin
            len_byte = 8'(cfg_record_len) + 8'd1;
        end else if ($urandom_range(0, 9) == 0) begin
            len_byte = 8'($urandom_range(12, 27));
        end else begin
            len_byte = 8'($urandom_range(1, 8));
        end
        fault = ($urandom_range(0, 99) < 85) ? CRC_GOOD : t_crc_fault'($urandom_range(1, 3));
        if (r < 6) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else if (r < 10) begin
            len_byte = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(28, 255));
            send_frame(len_byte, cmd, fault, 1'b0, -1);
        end else if (r < 14) begin
            send_frame(len_byte, cmd, fault, 1'b0, $urandom_range(1, 8));
        end else begin
            send_frame(len_byte, cmd, fault, $urandom_range(0, 9) == 0, -1);
        end
    endtask

    task automatic test_random_traffic();
        int start;
        int phase_end;
        int phase;
        start = framed_items;
        phase = 0;
        while (framed_items - start < RANDOM_ITEMS) begin
            quiesce();
            case (phase)
                0: begin
                    set_config(8'h00, 8'hFF, 5'd1);
                end
                1: begin
                    set_config(8'hFF, 8'h00, 5'd27);
                end
                2: begin
                    set_config(8'hA5, 8'h5A, 5'd17);
                end
                default: begin
                    set_config(8'($urandom), 8'($urandom), 5'($urandom_range(1, 27)));
                end
            endcase
            phase_end = framed_items + PHASE_ITEMS;
            while (framed_items < phase_end && framed_items - start < RANDOM_ITEMS) begin
                random_frame();
            end
            phase++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_hunting();
        test_store_commands();
        test_crc_and_length();
        test_query_heartbeat();
        test_unknown_and_tail();
        test_overlong();
        test_backpressure();
        test_random_traffic();
        quiesce();
        repeat (20) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            $display("%0t: %0d items still expected", $time, pending_events.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("** crc16_framed_command_receiver: PASSED **");
        end else begin
            $display("** crc16_framed_command_receiver: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/crcfr_pkg.sv
rtl/crcfr_front.sv
rtl/crcfr_queue.sv
rtl/crcfr_back.sv
rtl/crc16_framed_command_receiver.sv
tb/sv/tb.sv
